// ----- design/sesc_pkg.sv -----
// Shared types, status codes and the UTF-8 byte selector for the string escape decoder.
`default_nettype none

package sesc_pkg;

    localparam logic [2:0] ST_BYTE   = 3'd0;
    localparam logic [2:0] ST_END    = 3'd1;
    localparam logic [2:0] ST_EOF    = 3'd2;
    localparam logic [2:0] ST_DIGIT  = 3'd3;
    localparam logic [2:0] ST_ESCAPE = 3'd4;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  nbytes;
        logic [15:0] code;
    } t_cmd;

    function automatic logic [7:0] utf8_byte(input t_cmd cmd, input logic [1:0] idx);
        logic [7:0] b;
        b = cmd.code[7:0];
        case (cmd.nbytes)
            2'd2: begin
                if (idx == 2'd0) begin
                    b = {3'b110, cmd.code[10:6]};
                end else begin
                    b = {2'b10, cmd.code[5:0]};
                end
            end
            2'd3: begin
                if (idx == 2'd0) begin
                    b = {4'b1110, cmd.code[15:12]};
                end else if (idx == 2'd1) begin
                    b = {2'b10, cmd.code[11:6]};
                end else begin
                    b = {2'b10, cmd.code[5:0]};
                end
            end
            default: b = cmd.code[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- design/sesc_front.sv -----
// Front end: accepts raw bytes, tracks the escape state and issues one command per result group.
`default_nettype none

module sesc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_char_code,
    input  wire logic          i_end_of_input,
    output logic               o_cmd_valid,
    output sesc_pkg::t_cmd     o_cmd
);
    import sesc_pkg::*;

    typedef enum logic [3:0] {
        M_BODY = 4'b0001,
        M_ESC  = 4'b0010,
        M_OCT  = 4'b0100,
        M_HEX  = 4'b1000
    } t_mode;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    t_mode       r_mode, n_mode;
    logic [2:0]  r_count, n_count;
    logic [15:0] r_accum, n_accum;

    logic        is_oct;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [2:0]  count_inc;
    logic [15:0] oct_code;
    logic [15:0] hex_code;
    logic [15:0] emit_code;

    always_comb begin
        is_oct = (i_char_code >= 8'h30) && (i_char_code <= 8'h37);
        hex_ok = 1'b1;
        hex_val = i_char_code[3:0];
        if (i_char_code >= 8'h30 && i_char_code <= 8'h39) begin
            hex_val = i_char_code[3:0];
        end else if ((i_char_code >= 8'h61 && i_char_code <= 8'h66) ||
                     (i_char_code >= 8'h41 && i_char_code <= 8'h46)) begin
            hex_val = i_char_code[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
        count_inc = r_count + 3'd1;
        oct_code  = {7'd0, r_accum[5:0], i_char_code[2:0]};
        hex_code  = {r_accum[11:0], hex_val};
        emit_code = r_mode[3] ? hex_code : oct_code;
    end

    always_comb begin
        n_mode      = r_mode;
        n_count     = r_count;
        n_accum     = r_accum;
        o_cmd_valid = 1'b0;
        o_cmd       = '{status: ST_BYTE, nbytes: 2'd1, code: {8'd0, i_char_code}};
        if (i_accept) begin
            if (i_end_of_input) begin
                o_cmd_valid = 1'b1;
                o_cmd.code  = '0;
                o_cmd.status = (r_mode == M_OCT || r_mode == M_HEX) ? ST_DIGIT : ST_EOF;
                n_mode  = M_BODY;
                n_count = '0;
                n_accum = '0;
            end else begin
                unique case (r_mode) inside
                    M_BODY: begin
                        if (i_char_code == CH_QUOTE) begin
                            o_cmd_valid  = 1'b1;
                            o_cmd.status = ST_END;
                            o_cmd.code   = '0;
                        end else if (i_char_code == CH_BSL) begin
                            n_mode = M_ESC;
                        end else begin
                            o_cmd_valid = 1'b1;
                        end
                    end
                    M_ESC: begin
                        n_mode  = M_BODY;
                        n_count = '0;
                        n_accum = '0;
                        o_cmd_valid = 1'b1;
                        if (is_oct) begin
                            o_cmd_valid = 1'b0;
                            n_mode  = M_OCT;
                            n_count = 3'd1;
                            n_accum = {13'd0, i_char_code[2:0]};
                        end else if (i_char_code == CH_U) begin
                            o_cmd_valid = 1'b0;
                            n_mode = M_HEX;
                        end else begin
                            unique case (i_char_code)
                                8'h62:    o_cmd.code = 16'h0008;
                                8'h6E:    o_cmd.code = 16'h000A;
                                8'h74:    o_cmd.code = 16'h0009;
                                8'h66:    o_cmd.code = 16'h000C;
                                8'h72:    o_cmd.code = 16'h000D;
                                CH_QUOTE: o_cmd.code = {8'd0, CH_QUOTE};
                                CH_BSL:   o_cmd.code = {8'd0, CH_BSL};
                                default: begin
                                    o_cmd.code   = '0;
                                    o_cmd.status = ST_ESCAPE;
                                end
                            endcase
                        end
                    end
                    M_OCT, M_HEX: begin
                        if ((r_mode == M_OCT && !is_oct) || (r_mode == M_HEX && !hex_ok)) begin
                            o_cmd_valid  = 1'b1;
                            o_cmd.status = ST_DIGIT;
                            o_cmd.code   = '0;
                            n_mode  = M_BODY;
                            n_count = '0;
                            n_accum = '0;
                        end else if ((r_mode == M_OCT && count_inc == 3'd3) ||
                                     (r_mode == M_HEX && count_inc == 3'd4)) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.code  = emit_code;
                            if (emit_code < 16'h0080) begin
                                o_cmd.nbytes = 2'd1;
                            end else if (emit_code < 16'h0800) begin
                                o_cmd.nbytes = 2'd2;
                            end else begin
                                o_cmd.nbytes = 2'd3;
                            end
                            n_mode  = M_BODY;
                            n_count = '0;
                            n_accum = '0;
                        end else begin
                            n_count = count_inc;
                            n_accum = emit_code;
                        end
                    end
                    default: begin
                        n_mode  = M_BODY;
                        n_count = '0;
                        n_accum = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_BODY;
            r_count <= '0;
            r_accum <= '0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_accum <= n_accum;
        end
    end

endmodule

`default_nettype wire

// ----- design/sesc_queue.sv -----
// Command queue between the front end and the byte emitter.
`default_nettype none

module sesc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire sesc_pkg::t_cmd i_wr_cmd,
    input  wire logic          i_rd,
    output logic               o_full,
    output logic               o_valid,
    output sesc_pkg::t_cmd     o_rd_cmd
);
    import sesc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_wr, do_rd;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_rd_cmd = r_mem[r_rd_ptr];

    always_comb begin
        do_wr    = i_wr && !o_full;
        do_rd    = i_rd && o_valid;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- design/sesc_back.sv -----
// Back end: expands commands into result beats and holds the output register.
`default_nettype none

module sesc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire sesc_pkg::t_cmd i_q_cmd,
    output logic               o_q_rd,
    input  wire logic          i_pop,
    output logic               o_valid,
    output logic [7:0]         o_out_byte,
    output logic [2:0]         o_status,
    output logic               o_last
);
    import sesc_pkg::*;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic [2:0] r_out_status;
    logic       r_out_last;
    t_cmd       r_cur;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       load;

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_status   = r_out_status;
    assign o_last     = r_out_last;

    assign load   = !r_out_valid || i_pop;
    assign o_q_rd = load && !r_busy && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_busy) begin
                r_out_byte   <= utf8_byte(r_cur, r_idx);
                r_out_status <= r_cur.status;
                r_out_last   <= (r_idx == r_cur.nbytes - 2'd1);
            end else begin
                r_out_byte   <= utf8_byte(i_q_cmd, 2'd0);
                r_out_status <= i_q_cmd.status;
                r_out_last   <= (i_q_cmd.nbytes == 2'd1);
                r_cur        <= i_q_cmd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
            r_idx       <= '0;
        end else if (load) begin
            if (r_busy) begin
                r_out_valid <= 1'b1;
                if (r_idx == r_cur.nbytes - 2'd1) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + 2'd1;
            end else if (i_q_valid) begin
                r_out_valid <= 1'b1;
                r_busy      <= (i_q_cmd.nbytes != 2'd1);
                r_idx       <= 2'd1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/string_escape_to_utf8_decoder.sv -----
// Top level of the string literal escape decoder with UTF-8 output.
// A byte's first result beat goes through the command queue and then the output register.
// Throughput: one input byte per cycle; a code point emits one beat per UTF-8 byte, so two-
// and three-byte sequences hold the emitter for one beat per byte, absorbed by the queue
// until it fills and full stalls the input.
// Reset clears the escape state, the command queue and the output register; no clearing pass.
`default_nettype none

module string_escape_to_utf8_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_end_of_input,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic [2:0]      o_status,
    output logic            o_last
);
    import sesc_pkg::*;

    logic q_full;
    logic cmd_valid;
    t_cmd cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic q_rd;
    logic out_valid;

    assign full  = q_full;
    assign empty = !out_valid;

    sesc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (push && !q_full),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd)
    );

    sesc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (cmd_valid),
        .i_wr_cmd (cmd),
        .i_rd     (q_rd),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_rd_cmd (q_cmd)
    );

    sesc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_rd     (q_rd),
        .i_pop      (pop),
        .o_valid    (out_valid),
        .o_out_byte (o_out_byte),
        .o_status   (o_status),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire
